### hw/rtl/hmmb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmmb_pkg - shared types and constants of the min/max histogram block
// Beat payloads, cell chain control, register codes and sequencer states.
// ----------------------------------------------------------------------------
package hmmb_pkg;

  // default sizing
  localparam int HMMB_MAX_SAMPLES = 1024;
  localparam int HMMB_MAX_BINS    = 64;

  // configuration register file
  localparam int              CFG_W           = 7;
  localparam logic [CFG_W-1:0] BIN_COUNT_RESET = 7'd16;
  localparam int              BIN_VALUE_MAX   = 2047;

  typedef enum logic [0:0] {
    CFG_BIN_COUNT = 1'b0,
    CFG_CUM_MODE  = 1'b1
  } cfg_reg_e;

  // input beat
  typedef struct packed {
    logic signed [31:0] sample;
    logic               last_sample;
  } in_t;

  // result beat
  typedef struct packed {
    logic [5:0]         bin_index;
    logic signed [31:0] bin_center;
    logic [30:0]        half_width;
    logic [10:0]        bin_value;
    logic [16:0]        cdf_fraction;
    logic               last_bin;
  } out_t;

  // sample moving down the cell chain
  typedef struct packed {
    logic               valid;
    logic               placed;
    logic signed [31:0] sample;
  } pass_t;

  // broadcast control for all cells
  typedef struct packed {
    logic             clear;
    logic             edge_load;
    logic             shift;
    logic             cum;
    logic [CFG_W-1:0] nb;
    logic [31:0]      width;
  } ctrl_t;

  // pass sequencer
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RANGE_GO,
    ST_RANGE_WAIT,
    ST_SETUP,
    ST_FEED,
    ST_DRAIN,
    ST_FRAC_GO,
    ST_FRAC_WAIT,
    ST_EMIT
  } state_e;

endpackage
`default_nettype wire

### hw/rtl/hmmb_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmmb_div - restoring divider, one quotient bit per cycle
// Captures operands on start, runs DW steps, pulses done with the quotient.
// ----------------------------------------------------------------------------
module hmmb_div #(
  parameter int DW = 32,
  parameter int VW = 7
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output      logic          busy_o,
  output      logic          done_o,
  output      logic [DW-1:0] quot_o
);
  localparam int CNTW = $clog2(DW + 1);

  logic [VW:0]     rem_q, rem_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [VW-1:0]   dvs_q, dvs_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [VW:0]     trial;
  logic            ge;

  // one shift-subtract step
  always_comb begin
    trial  = {rem_q[VW-1:0], quo_q[DW-1]};
    ge     = trial >= {1'b0, dvs_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CNTW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? trial - {1'b0, dvs_q} : trial;
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

### hw/rtl/hmmb_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmmb_store - sample memory with fill count and running min/max
// Appends samples until full, one registered read port for the pass.
// ----------------------------------------------------------------------------
module hmmb_store #(
  parameter  int MAX_SAMPLES = 1024,
  localparam int CW          = $clog2(MAX_SAMPLES + 1),
  localparam int AW          = $clog2(MAX_SAMPLES)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_en_i,
  input  wire logic signed [31:0] wr_data_i,
  input  wire logic              clear_i,
  input  wire logic              rd_en_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  output      logic signed [31:0] rd_data_o,
  output      logic [CW-1:0]     count_o,
  output      logic signed [31:0] min_o,
  output      logic signed [31:0] max_o
);
  logic [31:0]        mem_q [MAX_SAMPLES];
  logic [31:0]        rd_data_q;
  logic [CW-1:0]      count_q, count_d;
  logic signed [31:0] min_q, min_d;
  logic signed [31:0] max_q, max_d;
  logic               push;

  // a sample is kept only while there is room
  assign push = wr_en_i && (count_q != CW'(MAX_SAMPLES));

  always_comb begin
    count_d = count_q;
    min_d   = min_q;
    max_d   = max_q;
    if (clear_i) begin
      count_d = '0;
      min_d   = 32'sh7FFF_FFFF;
      max_d   = 32'sh8000_0000;
    end else if (push) begin
      count_d = count_q + 1'b1;
      if (wr_data_i < min_q) min_d = wr_data_i;
      if (wr_data_i > max_q) max_d = wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      min_q   <= 32'sh7FFF_FFFF;
      max_q   <= 32'sh8000_0000;
    end else begin
      count_q <= count_d;
      min_q   <= min_d;
      max_q   <= max_d;
    end
  end

  // memory write port
  always_ff @(posedge clk_i) begin
    if (push && !clear_i) begin
      mem_q[count_q[AW-1:0]] <= wr_data_i;
    end
  end

  // memory read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign count_o   = count_q;
  assign min_o     = min_q;
  assign max_o     = max_q;

endmodule
`default_nettype wire

### hw/rtl/hmmb_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmmb_cell - one bin of the histogram chain
// Holds the bin's upper edge and count, tests each passing sample and
// hands it on; the count line shifts toward cell 0 for readout.
// ----------------------------------------------------------------------------
module hmmb_cell #(
  parameter int IDX = 0,
  parameter int CW  = 11
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire hmmb_pkg::ctrl_t    ctrl_i,
  input  wire hmmb_pkg::pass_t    pass_i,
  output      hmmb_pkg::pass_t    pass_o,
  input  wire logic signed [32:0] edge_i,
  output      logic signed [32:0] edge_o,
  input  wire logic [CW-1:0]      cnt_i,
  output      logic [CW-1:0]      cnt_o
);
  import hmmb_pkg::*;

  localparam logic [CFG_W-1:0] IdxC = CFG_W'(IDX);

  pass_t              pass_q, pass_d;
  logic signed [32:0] edge_q, edge_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               active;
  logic               is_last;
  logic               hit;
  logic               inc;

  // bin membership test against the upper edge
  always_comb begin
    active  = IdxC < ctrl_i.nb;
    is_last = ctrl_i.nb == (IdxC + 1'b1);
    hit     = pass_i.valid && active && !is_last &&
              ($signed({pass_i.sample[31], pass_i.sample}) < edge_q);
    // last bin takes what no earlier bin took, or everything when cumulative
    if (is_last) begin
      inc = pass_i.valid && (ctrl_i.cum || !pass_i.placed);
    end else begin
      inc = hit && (ctrl_i.cum || !pass_i.placed);
    end
    pass_d        = pass_i;
    pass_d.placed = pass_i.placed | hit;
  end

  // edge and count update
  always_comb begin
    edge_d = edge_q;
    cnt_d  = cnt_q;
    if (ctrl_i.edge_load) begin
      edge_d = edge_i + $signed({1'b0, ctrl_i.width});
    end
    if (ctrl_i.clear) begin
      cnt_d = '0;
    end else if (ctrl_i.shift) begin
      cnt_d = cnt_i;
    end else if (inc) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= '0;
      cnt_q  <= '0;
    end else begin
      pass_q <= pass_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    edge_q <= edge_d;
  end

  assign pass_o = pass_q;
  assign edge_o = edge_q;
  assign cnt_o  = cnt_q;

endmodule
`default_nettype wire

### hw/rtl/histogram_min_max_bins_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_min_max_bins_top - equal-width histogram and empirical CDF
// Stores a set of samples, then bins them over [min, max] and streams one
// result beat per bin.
// ----------------------------------------------------------------------------
// Samples are taken one beat per cycle into the sample memory while the
// running min and max are kept; a beat with last_sample set closes the set.
// The input then stalls for the binning pass of N stored samples and B bins:
// the range division (DW = max(32, clog2(MAX_SAMPLES+1) + 16), one quotient
// bit per cycle in the shared divider), the ripple of the bin edges down the
// cell chain, the read of the N samples from memory, the drain until the last
// sample has cleared the chain, then the readout of the bins, where in
// cumulative mode the same divider forms each fraction. Result beats sit
// in an output register, so the next set is accepted as soon as the last
// bin is loaded.
// No clearing pass is needed after reset: the fill count bounds every read.
// ----------------------------------------------------------------------------
module histogram_min_max_bins_top #(
  parameter int MAX_SAMPLES = hmmb_pkg::HMMB_MAX_SAMPLES,
  parameter int MAX_BINS    = hmmb_pkg::HMMB_MAX_BINS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire hmmb_pkg::in_t                in_data_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      hmmb_pkg::out_t               out_data_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [0:0]                   cfg_idx_i,
  input  wire logic [hmmb_pkg::CFG_W-1:0]   cfg_data_i
);
  import hmmb_pkg::*;

  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int AW   = $clog2(MAX_SAMPLES);
  localparam int DivW = (CW + 16 > 32) ? CW + 16 : 32;
  localparam int DvsW = (CW > CFG_W) ? CW : CFG_W;
  localparam int TW   = $clog2(MAX_BINS + 2) + 1;

  // configuration
  logic [CFG_W-1:0] bin_count_q;
  logic             cum_q;
  logic [CFG_W-1:0] nb;

  // sequencer and datapath registers
  state_e         state_q, state_d;
  logic [31:0]    w_q, w_d;
  logic [31:0]    center_q, center_d;
  logic [CFG_W-1:0] j_q, j_d;
  logic [TW-1:0]  tmr_q, tmr_d;
  logic [CW-1:0]  p_q, p_d;
  logic [16:0]    frac_q, frac_d;
  logic           rd_valid_q;
  logic           out_valid_q, out_valid_d;
  out_t           out_data_q, out_data_d;

  // store signals
  logic               wr_en;
  logic               set_clear;
  logic               rd_en;
  logic signed [31:0] rd_data;
  logic [CW-1:0]      stored_cnt;
  logic signed [31:0] run_min;
  logic signed [31:0] run_max;

  // divider signals
  logic            div_start;
  logic [DivW-1:0] div_dividend;
  logic [DvsW-1:0] div_divisor;
  logic            div_busy;
  logic            div_done;
  logic [DivW-1:0] div_quot;

  // chain signals
  ctrl_t              ctrl;
  pass_t              pass_w [MAX_BINS+1];
  logic signed [32:0] edge_w [MAX_BINS+1];
  logic [CW-1:0]      cnt_w  [MAX_BINS+1];

  logic [32:0] diff;
  logic [31:0] range;
  logic        out_free;
  logic [31:0] cnt_wide;
  logic        is_last_bin;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_q <= BIN_COUNT_RESET;
      cum_q       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_BIN_COUNT: bin_count_q <= cfg_data_i;
        CFG_CUM_MODE:  cum_q       <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  // bins in effect
  always_comb begin
    if (bin_count_q == '0) begin
      nb = CFG_W'(1);
    end else if (bin_count_q > CFG_W'(MAX_BINS)) begin
      nb = CFG_W'(MAX_BINS);
    end else begin
      nb = bin_count_q;
    end
  end

  // range of the set, clamped at zero
  always_comb begin
    diff  = {run_max[31], run_max} - {run_min[31], run_min};
    range = diff[32] ? '0 : diff[31:0];
  end

  assign wr_en       = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cnt_wide    = 32'(cnt_w[0]);
  assign is_last_bin = j_q == (nb - 1'b1);

  // pass sequencer
  always_comb begin
    state_d      = state_q;
    w_d          = w_q;
    center_d     = center_q;
    j_d          = j_q;
    tmr_d        = tmr_q;
    p_d          = p_q;
    frac_d       = frac_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    in_stall_o   = 1'b1;
    set_clear    = 1'b0;
    rd_en        = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    ctrl.clear     = 1'b0;
    ctrl.edge_load = 1'b0;
    ctrl.shift     = 1'b0;
    ctrl.cum       = cum_q;
    ctrl.nb        = nb;
    ctrl.width     = w_q;
    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i && in_data_i.last_sample) begin
          state_d = ST_RANGE_GO;
        end
      end
      ST_RANGE_GO: begin
        div_start    = 1'b1;
        div_dividend = DivW'(range);
        div_divisor  = DvsW'(nb);
        state_d      = ST_RANGE_WAIT;
      end
      ST_RANGE_WAIT: begin
        if (div_done) begin
          w_d     = div_quot[31:0];
          tmr_d   = '0;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        // edges ripple one cell per cycle; counters clear
        ctrl.edge_load = 1'b1;
        ctrl.clear     = 1'b1;
        center_d       = run_min + {1'b0, w_q[31:1]};
        tmr_d          = tmr_q + 1'b1;
        p_d            = '0;
        if (tmr_q == TW'(MAX_BINS - 1)) begin
          tmr_d   = '0;
          state_d = (stored_cnt == '0) ? ST_DRAIN : ST_FEED;
        end
      end
      ST_FEED: begin
        rd_en = 1'b1;
        p_d   = p_q + 1'b1;
        if (p_q == stored_cnt - 1'b1) begin
          tmr_d   = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        tmr_d = tmr_q + 1'b1;
        j_d   = '0;
        if (tmr_q == TW'(MAX_BINS + 1)) begin
          state_d = cum_q ? ST_FRAC_GO : ST_EMIT;
        end
      end
      ST_FRAC_GO: begin
        div_start    = 1'b1;
        div_dividend = DivW'({cnt_w[0], 16'b0});
        div_divisor  = DvsW'(stored_cnt);
        state_d      = ST_FRAC_WAIT;
      end
      ST_FRAC_WAIT: begin
        if (div_done) begin
          frac_d  = (stored_cnt == '0) ? '0 : div_quot[16:0];
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_data_d.bin_index    = j_q[5:0];
          out_data_d.bin_center   = center_q;
          out_data_d.half_width   = w_q[31:1];
          out_data_d.bin_value    = (cnt_wide > 32'(BIN_VALUE_MAX)) ?
                                    11'(BIN_VALUE_MAX) : cnt_wide[10:0];
          out_data_d.cdf_fraction = cum_q ? frac_q : '0;
          out_data_d.last_bin     = is_last_bin;
          ctrl.shift              = 1'b1;
          center_d                = center_q + w_q;
          j_d                     = j_q + 1'b1;
          if (is_last_bin) begin
            set_clear = 1'b1;
            state_d   = ST_LOAD;
          end else begin
            state_d = cum_q ? ST_FRAC_GO : ST_EMIT;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      tmr_q       <= '0;
      p_q         <= '0;
      j_q         <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tmr_q       <= tmr_d;
      p_q         <= p_d;
      j_q         <= j_d;
      rd_valid_q  <= rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q        <= w_d;
    center_q   <= center_d;
    frac_q     <= frac_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // sample memory
  hmmb_store #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (in_data_i.sample),
    .clear_i   (set_clear),
    .rd_en_i   (rd_en),
    .rd_addr_i (p_q[AW-1:0]),
    .rd_data_o (rd_data),
    .count_o   (stored_cnt),
    .min_o     (run_min),
    .max_o     (run_max)
  );

  // shared divider for bin width and fractions
  hmmb_div #(
    .DW(DivW),
    .VW(DvsW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // chain head: memory read data, edge seed, empty count tail
  always_comb begin
    pass_w[0].valid  = rd_valid_q;
    pass_w[0].placed = 1'b0;
    pass_w[0].sample = rd_data;
    edge_w[0]        = $signed({run_min[31], run_min});
    cnt_w[MAX_BINS]  = '0;
  end

  // row of bin cells
  for (genvar g = 0; g < MAX_BINS; g++) begin : g_cell
    hmmb_cell #(
      .IDX(g),
      .CW (CW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .pass_i (pass_w[g]),
      .pass_o (pass_w[g+1]),
      .edge_i (edge_w[g]),
      .edge_o (edge_w[g+1]),
      .cnt_i  (cnt_w[g+1]),
      .cnt_o  (cnt_w[g])
    );
  end

`ifndef SYNTH
  // divider results only arrive while the sequencer waits for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_RANGE_WAIT || state_q == ST_FRAC_WAIT))
    else $error("divider done outside a wait state");

  // no division is in flight while samples are being loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |-> !div_busy)
    else $error("divider busy during load");

  // fill count stays within the memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(stored_cnt) <= MAX_SAMPLES)
    else $error("stored count beyond memory depth");

  // every sample has left the chain before counts are read out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT || state_q == ST_FRAC_GO) |-> !pass_w[MAX_BINS].valid)
    else $error("sample still in chain at readout");

  // a load beat never lands while the memory is being read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> !wr_en)
    else $error("sample write during pass");
`endif

endmodule
`default_nettype wire
